FILE: design/krme_pkg.sv
`default_nettype none

package krme_pkg;

  // Sizes
  localparam int MaxOrder    = 4;
  localparam int CordicSteps = 16;
  localparam int IdxW        = 4;
  localparam int OrderW      = 3;
  localparam int FracW       = 13;
  localparam int CoefW       = 16;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 13;
  localparam int CordW       = 34;  // Q2.30 plus headroom
  localparam int MagW        = 15;  // 0 .. 16384

  // Pipeline depth: angle stage, CORDIC stages, saturate, products, output
  localparam int Latency = 1 + CordicSteps + 1 + MaxOrder + 1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgMixFraction = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgKronOrder   = 1'd1;

  localparam logic [FracW-1:0]  MixFractionRst = 13'd0;
  localparam logic [OrderW-1:0] KronOrderRst   = 3'd3;

  // Fixed-point constants
  localparam logic [29:0]          PiQuarterQ30 = 30'd843314857;
  localparam logic signed [CordW-1:0] GainQ30   = 34'sd652032874;
  localparam logic [MagW-1:0]      OneQ14       = 15'd16384;

  // atan(2^-i) in Q2.30, truncated
  localparam logic [31:0] AtanQ30 [24] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Per-item factor selection, travels with the beat
  typedef struct packed {
    logic [MaxOrder-1:0] active;  // bit position below the order
    logic [MaxOrder-1:0] use_s;   // row and column bits differ
    logic                neg;     // odd count of -s factors
  } krme_tag_t;

endpackage

`default_nettype wire

FILE: design/kronecker_rotation_matrix_entry_top.sv
// Each start beat yields one done_o strobe at the end of the pipeline below.
// Throughput: one entry per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the 16-stage CORDIC that recomputes cos/sin per beat,
// plus the angle stage, saturation, four product stages and the output register.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the
// register defaults: mix_fraction 0, kron_order 3.
`default_nettype none

module kronecker_rotation_matrix_entry_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [krme_pkg::IdxW-1:0]         row_index_i,
  input  wire logic [krme_pkg::IdxW-1:0]         col_index_i,
  output logic                                   done_o,
  output logic signed [krme_pkg::CoefW-1:0]      coefficient_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [krme_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [krme_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  localparam int Cs = krme_pkg::CordicSteps;
  localparam int Mo = krme_pkg::MaxOrder;
  localparam int Cw = krme_pkg::CordW;
  localparam int Mw = krme_pkg::MagW;

  logic [krme_pkg::FracW-1:0]  mix_fraction_q;
  logic [krme_pkg::OrderW-1:0] kron_order_q;
  logic                        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_fraction_q <= krme_pkg::MixFractionRst;
      kron_order_q   <= krme_pkg::KronOrderRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        krme_pkg::CfgMixFraction: mix_fraction_q <= cfg_wdata_i[krme_pkg::FracW-1:0];
        krme_pkg::CfgKronOrder:   kron_order_q   <= cfg_wdata_i[krme_pkg::OrderW-1:0];
        default: ;
      endcase
    end
  end

  // Entry: clamp order, build factor selection
  logic [krme_pkg::OrderW-1:0] order_eff;
  krme_pkg::krme_tag_t         tag_in;

  always_comb begin
    if (kron_order_q == '0) begin
      order_eff = krme_pkg::OrderW'(1);
    end else if (kron_order_q > krme_pkg::OrderW'(Mo)) begin
      order_eff = krme_pkg::OrderW'(Mo);
    end else begin
      order_eff = kron_order_q;
    end
    for (int b = 0; b < Mo; b++) begin
      tag_in.active[b] = (krme_pkg::OrderW'(b) < order_eff);
      tag_in.use_s[b]  = row_index_i[b] ^ col_index_i[b];
    end
    tag_in.neg = ^(row_index_i[Mo-1:0] & ~col_index_i[Mo-1:0] & tag_in.active);
  end

  // Angle stage: a = (frac * pi/4 + 2048) >> 12, Q2.30
  logic [42:0] ang_prod;
  assign ang_prod = 43'(mix_fraction_q) * 43'(krme_pkg::PiQuarterQ30) + 43'd2048;

  logic                       cv_q   [Cs+1];
  logic signed [Cw-1:0]       x_q    [Cs+1];
  logic signed [Cw-1:0]       y_q    [Cs+1];
  logic signed [Cw-1:0]       z_q    [Cs+1];
  krme_pkg::krme_tag_t        ctag_q [Cs+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= krme_pkg::GainQ30;
    y_q[0]    <= '0;
    z_q[0]    <= Cw'(signed'({1'b0, ang_prod[42:12]}));
    ctag_q[0] <= tag_in;
  end

  // CORDIC rotation, one step per stage
  for (genvar i = 0; i < Cs; i++) begin : g_cordic
    logic signed [Cw-1:0] dx, dy, at;
    logic signed [Cw-1:0] x_d, y_d, z_d;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = Cw'(signed'({1'b0, krme_pkg::AtanQ30[i]}));

    always_comb begin
      if (z_q[i] >= 0) begin
        x_d = x_q[i] - dx;
        y_d = y_q[i] + dy;
        z_d = z_q[i] - at;
      end else begin
        x_d = x_q[i] + dx;
        y_d = y_q[i] - dy;
        z_d = z_q[i] + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[i+1]    <= x_d;
      y_q[i+1]    <= y_d;
      z_q[i+1]    <= z_d;
      ctag_q[i+1] <= ctag_q[i];
    end
  end

  // Round to Q1.14 and saturate to [0, 1.0]
  function automatic logic [Mw-1:0] to_q14_sat(input logic signed [Cw-1:0] v);
    logic signed [Cw-1:0] t;
    logic signed [Cw-17:0] q;
    t = v + Cw'(32768);
    q = t[Cw-1:16];
    if (q < 0) begin
      return '0;
    end else if (q > (Cw-16)'(krme_pkg::OneQ14)) begin
      return krme_pkg::OneQ14;
    end else begin
      return q[Mw-1:0];
    end
  endfunction

  logic                 mv_q   [Mo+1];
  logic [Mw-1:0]        c_q    [Mo+1];
  logic [Mw-1:0]        s_q    [Mo+1];
  logic [Mw-1:0]        mag_q  [Mo+1];
  krme_pkg::krme_tag_t  mtag_q [Mo+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q[0] <= 1'b0;
    end else begin
      mv_q[0] <= cv_q[Cs];
    end
  end

  always_ff @(posedge clk_i) begin
    c_q[0]    <= to_q14_sat(x_q[Cs]);
    s_q[0]    <= to_q14_sat(y_q[Cs]);
    mag_q[0]  <= krme_pkg::OneQ14;
    mtag_q[0] <= ctag_q[Cs];
  end

  // Product chain, one factor per stage
  for (genvar b = 0; b < Mo; b++) begin : g_mul
    logic [Mw-1:0]   f;
    logic [2*Mw-1:0] prod;
    logic [Mw-1:0]   mag_d;

    assign f    = mtag_q[b].use_s[b] ? s_q[b] : c_q[b];
    assign prod = mag_q[b] * f + (2*Mw)'(8192);

    always_comb begin
      if (mtag_q[b].active[b]) begin
        mag_d = prod[Mw+13:14];
      end else begin
        mag_d = mag_q[b];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[b+1] <= 1'b0;
      end else begin
        mv_q[b+1] <= mv_q[b];
      end
    end

    always_ff @(posedge clk_i) begin
      c_q[b+1]    <= c_q[b];
      s_q[b+1]    <= s_q[b];
      mag_q[b+1]  <= mag_d;
      mtag_q[b+1] <= mtag_q[b];
    end
  end

  // Output register: apply sign
  logic                             done_q;
  logic signed [krme_pkg::CoefW-1:0] coefficient_q;
  logic signed [krme_pkg::CoefW-1:0] coefficient_d;

  assign coefficient_d = mtag_q[Mo].neg ? -krme_pkg::CoefW'(mag_q[Mo])
                                        :  krme_pkg::CoefW'(mag_q[Mo]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mv_q[Mo];
    end
  end

  always_ff @(posedge clk_i) begin
    coefficient_q <= coefficient_d;
  end

  assign done_o        = done_q;
  assign coefficient_o = coefficient_q;

`ifndef SYNTHESIS
  // Every accepted beat comes out after the fixed latency
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(krme_pkg::Latency) done_o)
    else $error("accepted beat did not produce a result");

  // No result without a matching accepted beat
  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, krme_pkg::Latency))
    else $error("result without accepted beat");

  // Coefficient stays within [-1.0, 1.0]
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (coefficient_o <= 16'sd16384) && (coefficient_o >= -16'sd16384))
    else $error("coefficient out of range");
`endif

endmodule

`default_nettype wire
